/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/rau_pkg.sv */
package rau_pkg;

  localparam int OpW = 3;
  localparam int StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_ZERO_DEN = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_GCD,
    S_DONE,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic prep;
    logic div_start;
    logic div_step;
    logic gcd_step;
    logic finish;
  } rau_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic trivial;
    logic gcd_done;
  } rau_stat_t;

endpackage

/* rtl/rau_if.sv */
interface rau_in_if #(parameter int MAG_WIDTH = 16);
  logic                 valid;
  logic                 ready;
  logic [2:0]           operation;
  logic                 a_negative;
  logic [MAG_WIDTH-1:0] a_magnitude;
  logic [MAG_WIDTH-1:0] a_divisor;
  logic                 b_negative;
  logic [MAG_WIDTH-1:0] b_magnitude;
  logic [MAG_WIDTH-1:0] b_divisor;

  modport source (output valid, operation, a_negative, a_magnitude, a_divisor,
                  b_negative, b_magnitude, b_divisor, input ready);
  modport sink (input valid, operation, a_negative, a_magnitude, a_divisor,
                b_negative, b_magnitude, b_divisor, output ready);
endinterface

interface rau_out_if #(parameter int MAG_WIDTH = 16);
  logic                 valid;
  logic                 ready;
  logic                 res_negative;
  logic [MAG_WIDTH-1:0] res_magnitude;
  logic [MAG_WIDTH-1:0] res_divisor;
  logic                 less_flag;
  logic                 equal_flag;
  logic                 greater_flag;
  logic [1:0]           status;

  modport source (output valid, res_negative, res_magnitude, res_divisor,
                  less_flag, equal_flag, greater_flag, status, input ready);
  modport sink (input valid, res_negative, res_magnitude, res_divisor,
                less_flag, equal_flag, greater_flag, status, output ready);
endinterface

/* rtl/rau_ctrl.sv */
module rau_ctrl import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  rau_stat_t stat,
  output rau_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (stat.trivial) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        // Shared divider first yields numerator mod den, then GCD steps, then
        // numerator / gcd and den / gcd; the datapath sequences the phases.
        cmd.div_step = 1'b1;
        cmd.gcd_step = 1'b1;
        if (stat.gcd_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load  = 1'b1;
            state_nxt = S_PREP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* rtl/rau_dp.sv */
module rau_dp import rau_pkg::*; #(
  parameter int MAG_WIDTH = 16
) (
  input  logic                 clk,
  input  rau_cmd_t             cmd,
  output rau_stat_t            stat,
  input  logic [2:0]           operation,
  input  logic                 a_negative,
  input  logic [MAG_WIDTH-1:0] a_magnitude,
  input  logic [MAG_WIDTH-1:0] a_divisor,
  input  logic                 b_negative,
  input  logic [MAG_WIDTH-1:0] b_magnitude,
  input  logic [MAG_WIDTH-1:0] b_divisor,
  output logic                 res_negative,
  output logic [MAG_WIDTH-1:0] res_magnitude,
  output logic [MAG_WIDTH-1:0] res_divisor,
  output logic                 less_flag,
  output logic                 equal_flag,
  output logic                 greater_flag,
  output logic [1:0]           status
);

  localparam int PW = 2 * MAG_WIDTH;   // product width
  localparam int NW = PW + 1;          // numerator width, sum carry included
  localparam int CW = $clog2(NW + 1);

  // Divider phases: numerator mod den, Euclid decision, Euclid division pass,
  // numerator / gcd, den / gcd, finished.
  typedef enum logic [2:0] {PH_MOD, PH_GCD, PH_EUC, PH_QUO, PH_DEN, PH_END} phase_t;

  logic [2:0]           op_r;
  logic                 sa_r, sb_r;
  logic [MAG_WIDTH-1:0] ad_r, bm_r, bd_r;
  logic [PW-1:0]        x_r, y_r, p_r, den_r;
  logic [NW-1:0]        num_r;
  logic                 neg_r;
  logic [1:0]           pre_st_r;
  logic                 lt_r, eq_r, gt_r;
  // Divider and GCD state.
  phase_t               ph_r;
  logic [CW-1:0]        cnt_r;
  logic [NW-1:0]        dq_r;      // dividend shifting out / quotient shifting in
  logic [PW-1:0]        rem_r;
  logic [PW-1:0]        dsr_r;     // divisor
  logic [PW-1:0]        gx_r, gy_r;
  logic [PW-1:0]        dden_r;    // den / g result
  logic [NW-1:0]        qnum_r;    // numerator / g result
  // Registered result.
  logic                 res_neg_r;
  logic [MAG_WIDTH-1:0] res_mag_r, res_div_r;
  logic                 lt_out_r, eq_out_r, gt_out_r;
  logic [1:0]           st_out_r;

  // Operand decode, taken by the prep command.
  logic                 sy, na, nb, mag_lt;
  logic                 lt_nxt, eq_nxt, gt_nxt, neg_nxt;
  logic [1:0]           pre_st_nxt;
  logic [NW-1:0]        num_nxt;
  logic [PW-1:0]        den_nxt;
  // Result formatting, taken by the finish command.
  logic                 fin_neg;
  logic [MAG_WIDTH-1:0] fin_mag, fin_div;
  logic [1:0]           fin_st;

  logic [PW:0]          rem_sh;
  logic                 sub_ok;
  logic [PW:0]          rem_sub;
  logic                 div_last;
  logic [NW-1:0]        quo_nxt;

  assign rem_sh   = {rem_r, dq_r[NW-1]};
  assign sub_ok   = rem_sh >= {1'b0, dsr_r};
  assign rem_sub  = sub_ok ? rem_sh - {1'b0, dsr_r} : rem_sh;
  assign quo_nxt  = {dq_r[NW-2:0], sub_ok};
  assign div_last = (cnt_r == CW'(NW - 1));
  assign stat.trivial  = (pre_st_r != ST_OK) || (op_r >= OP_CMP) || (num_r == '0);
  assign stat.gcd_done = (ph_r == PH_END);

  always_comb begin
    sy         = (op_r == OP_SUB) ? !sb_r : sb_r;
    na         = sa_r && (x_r != '0);
    nb         = sb_r && (y_r != '0);
    mag_lt     = x_r < y_r;
    lt_nxt     = 1'b0;
    eq_nxt     = 1'b0;
    gt_nxt     = 1'b0;
    pre_st_nxt = ST_OK;
    num_nxt    = '0;
    neg_nxt    = 1'b0;
    den_nxt    = den_r;
    // Unused operation codes skip even the zero denominator check.
    if (op_r <= OP_CMP && (ad_r == '0 || bd_r == '0)) begin
      pre_st_nxt = ST_ZERO_DEN;
    end else if (op_r == OP_CMP) begin
      if (na != nb) begin
        lt_nxt = na;
        gt_nxt = !na;
      end else if (x_r == y_r) begin
        eq_nxt = 1'b1;
      end else begin
        lt_nxt = na ? !mag_lt : mag_lt;
        gt_nxt = na ? mag_lt : !mag_lt;
      end
    end else if (op_r == OP_ADD || op_r == OP_SUB) begin
      if (sa_r == sy) begin
        num_nxt = {1'b0, x_r} + {1'b0, y_r};
        neg_nxt = sa_r;
      end else if (!mag_lt) begin
        num_nxt = {1'b0, x_r - y_r};
        neg_nxt = sa_r;
      end else begin
        num_nxt = {1'b0, y_r - x_r};
        neg_nxt = sy;
      end
    end else if (op_r == OP_MUL) begin
      num_nxt = {1'b0, p_r};
      neg_nxt = sa_r != sb_r;
    end else if (op_r == OP_DIV) begin
      if (bm_r == '0) begin
        pre_st_nxt = ST_DIV_ZERO;
      end else begin
        num_nxt = {1'b0, x_r};
        den_nxt = PW'(ad_r) * PW'(bm_r);
        neg_nxt = sa_r != sb_r;
      end
    end
  end

  always_comb begin
    fin_neg = 1'b0;
    fin_mag = '0;
    fin_div = MAG_WIDTH'(1);
    fin_st  = pre_st_r;
    if (!stat.trivial) begin
      if (qnum_r[NW-1:MAG_WIDTH] != '0 || dden_r[PW-1:MAG_WIDTH] != '0) begin
        fin_st = ST_OVERFLOW;
      end else begin
        fin_neg = neg_r;
        fin_mag = qnum_r[MAG_WIDTH-1:0];
        fin_div = dden_r[MAG_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= operation;
      sa_r <= a_negative;  sb_r <= b_negative;
      ad_r <= a_divisor;
      bm_r <= b_magnitude; bd_r <= b_divisor;
      x_r  <= PW'(a_magnitude) * PW'(b_divisor);
      y_r  <= PW'(b_magnitude) * PW'(a_divisor);
      p_r  <= PW'(a_magnitude) * PW'(b_magnitude);
      den_r <= PW'(a_divisor) * PW'(b_divisor);
    end else if (cmd.prep) begin
      lt_r     <= lt_nxt;
      eq_r     <= eq_nxt;
      gt_r     <= gt_nxt;
      pre_st_r <= pre_st_nxt;
      num_r    <= num_nxt;
      neg_r    <= neg_nxt;
      den_r    <= den_nxt;
    end
    if (cmd.div_start) begin
      ph_r  <= PH_MOD;
      cnt_r <= '0;
      dq_r  <= num_r;
      rem_r <= '0;
      dsr_r <= den_r;
    end else if (cmd.gcd_step && ph_r == PH_GCD) begin
      // Euclid: a zero remainder leaves the GCD in gx, else divide gx by gy.
      cnt_r <= '0;
      rem_r <= '0;
      if (gy_r == '0) begin
        dsr_r <= gx_r;
        dq_r  <= num_r;
        ph_r  <= PH_QUO;
      end else begin
        dsr_r <= gy_r;
        dq_r  <= {1'b0, gx_r};
        ph_r  <= PH_EUC;
      end
    end else if (cmd.div_step && ph_r != PH_END) begin
      if (!div_last) begin
        // One restoring-division bit per cycle.
        rem_r <= rem_sub[PW-1:0];
        dq_r  <= quo_nxt;
        cnt_r <= cnt_r + CW'(1);
      end else begin
        cnt_r <= '0;
        unique case (ph_r)
          PH_MOD, PH_EUC: begin
            gx_r <= (ph_r == PH_MOD) ? den_r : gy_r;
            gy_r <= rem_sub[PW-1:0];
            ph_r <= PH_GCD;
          end
          PH_QUO: begin
            // Quotient of numerator ready; now divide den by g.
            qnum_r <= quo_nxt;
            dq_r   <= {1'b0, den_r};
            rem_r  <= '0;
            ph_r   <= PH_DEN;
          end
          default: begin
            dden_r <= quo_nxt[PW-1:0];
            ph_r   <= PH_END;
          end
        endcase
      end
    end
    if (cmd.finish) begin
      res_neg_r <= fin_neg;
      res_mag_r <= fin_mag;
      res_div_r <= fin_div;
      lt_out_r  <= lt_r;
      eq_out_r  <= eq_r;
      gt_out_r  <= gt_r;
      st_out_r  <= fin_st;
    end
  end

  assign res_negative  = res_neg_r;
  assign res_magnitude = res_mag_r;
  assign res_divisor   = res_div_r;
  assign less_flag     = lt_out_r;
  assign equal_flag    = eq_out_r;
  assign greater_flag  = gt_out_r;
  assign status        = st_out_r;

endmodule

/* rtl/rational_arithmetic_unit.sv */
// Rational arithmetic unit.
// Input channel (in_*): one transaction carries an operation code and two
// sign-magnitude fractions. Output channel (out_*): one transaction per input,
// carrying the reduced fraction, compare flags and a status code.
// Add, subtract, multiply and divide form a full-width numerator and
// denominator, then reduce them by the Euclidean GCD. Every Euclid remainder
// and both divisions by the GCD run on one shared restoring divider that takes
// one bit per cycle over the 2*MAG_WIDTH+1 bit numerator.
// Compare, error cases and zero results bypass the divider and the GCD steps.
// One item is in flight at a time; in_ready is high when idle or when the
// finished result is taken in the same cycle.
// The result is held stable while out_ready is low; no new item is taken
// until it has been delivered.
// Reset (rst_n low, synchronous) returns the controller to idle and drops any
// item in progress.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int MAG_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);

  rau_cmd_t  cmd;
  rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rau_dp #(.MAG_WIDTH(MAG_WIDTH)) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (in_ch.operation),
    .a_negative    (in_ch.a_negative),
    .a_magnitude   (in_ch.a_magnitude),
    .a_divisor     (in_ch.a_divisor),
    .b_negative    (in_ch.b_negative),
    .b_magnitude   (in_ch.b_magnitude),
    .b_divisor     (in_ch.b_divisor),
    .res_negative  (out_ch.res_negative),
    .res_magnitude (out_ch.res_magnitude),
    .res_divisor   (out_ch.res_divisor),
    .less_flag     (out_ch.less_flag),
    .equal_flag    (out_ch.equal_flag),
    .greater_flag  (out_ch.greater_flag),
    .status        (out_ch.status)
  );

endmodule

/* rtl/rau_checker.sv */
`include "assert_macros.svh"

module rau_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       less_flag,
  input logic       equal_flag,
  input logic       greater_flag,
  input logic [1:0] status
);

  `ASSERT_IMPL(a_flags_onehot0, clk, rst_n, out_valid, $onehot0({less_flag, equal_flag, greater_flag}))
  `ASSERT_IMPL(a_ready_when_busy, clk, rst_n, out_valid && !out_ready, !in_ready)
  `ASSERT_NEXT(a_accept_no_out, clk, rst_n, in_valid && in_ready, !out_valid)
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status))

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .less_flag    (out_ch.less_flag),
  .equal_flag   (out_ch.equal_flag),
  .greater_flag (out_ch.greater_flag),
  .status       (out_ch.status)
);
